[hw/rtl/stbe_pkg.sv]
// Package for the sprite tile bitplane encoder: sizes, state type and the plane split function.
`default_nettype none

package stbe_pkg;

    // Tile geometry.
    localparam int TILE_ROWS   = 16;
    localparam int TILE_PLANES = 4;
    localparam int PIX_BITS    = 4;
    localparam int ROW_W       = 64;
    localparam int WORD_W      = 16;
    localparam int ROW_IDX_W   = 4;
    localparam int PLANE_W     = 2;
    localparam int STORE_DEPTH = TILE_ROWS * TILE_PLANES;
    localparam int STORE_IDX_W = ROW_IDX_W + PLANE_W;
    localparam int MEM_W       = WORD_W * TILE_PLANES;

    // Row index of the last row of a tile and address of the last stored word.
    localparam logic [ROW_IDX_W-1:0]   LAST_ROW  = ROW_IDX_W'(TILE_ROWS - 1);
    localparam logic [STORE_IDX_W-1:0] LAST_WORD = STORE_IDX_W'(STORE_DEPTH - 1);

    // Control states: rows are filled in, then the tile is drained.
    typedef enum logic {
        ST_FILL,
        ST_DRAIN
    } t_state;

    // Gathers bit "plane" of every pixel of a row; the leftmost pixel lands in the MSB.
    function automatic logic [WORD_W-1:0] plane_of_row(input logic [ROW_W-1:0]   pix,
                                                       input logic [PLANE_W-1:0] plane);
        logic [WORD_W-1:0] word;
        word = '0;
        for (int k = 0; k < WORD_W; k++) begin
            word[WORD_W-1-k] = pix[PIX_BITS*k + int'(plane)];
        end
        return word;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/stbe_ram.sv]
// Generic simple dual-port RAM with one write port and a registered, enabled read port.
`default_nettype none

module stbe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data register holds its value while no read is enabled.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sprite_tile_bitplane_encoder.sv]
// Top level of the sprite tile bitplane encoder: row memory, drain sequencer and output register.
//
// The input channel takes one tile row per transfer: sixteen 4-bit pixels in i_row_pixels,
// pixel 0 (leftmost) in the low nibble. Each row is split into four 16-bit plane words and
// written as one entry of a 16 x 64 row memory in the cycle of its transfer.
// Rows one to fifteen produce no output. The transfer of the sixteenth row starts a drain:
// 64 words leave on the output channel, plane 0 rows 0 to 15 first, then planes 1, 2, 3.
// o_last_word marks the 64th word. The first word passes the memory's read register and
// the output register; without output stall the words follow at one per cycle.
// While the memory is read out (one read per cycle on its single read port, without output
// stall) o_in_stall is high; the next tile's rows are taken from the cycle after the last read.
// When i_out_stall is high the output word holds, one more word waits in the memory's read
// register, and reading pauses until the output moves again.
// Reset (synchronous, active low) zeroes the row counter, empties the output and returns
// to row filling; the memory is not cleared, as every entry is written before it is read.
`default_nettype none

module sprite_tile_bitplane_encoder
    import stbe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [ROW_W-1:0]  i_row_pixels,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [WORD_W-1:0] o_plane_word,
    output logic                   o_last_word
);

    t_state                   r_state, n_state;
    logic [ROW_IDX_W-1:0]     r_row_idx;
    logic [STORE_IDX_W-1:0]   r_rd_idx;
    logic                     r_rd_pend;
    logic [PLANE_W-1:0]       r_rd_plane;
    logic                     r_rd_last;
    logic                     r_out_valid;
    logic [WORD_W-1:0]        r_out_word;
    logic                     r_out_last;

    logic                     in_xfer;
    logic                     rd_issue;
    logic                     move;
    logic [MEM_W-1:0]         wr_data;
    logic [MEM_W-1:0]         rd_data;

    // Split the incoming row into its four plane words.
    always_comb begin
        for (int p = 0; p < TILE_PLANES; p++) begin
            wr_data[WORD_W*p +: WORD_W] = plane_of_row(i_row_pixels, PLANE_W'(p));
        end
    end

    // Row memory: one entry per tile row, the four plane words side by side.
    stbe_ram #(
        .WIDTH (MEM_W),
        .DEPTH (TILE_ROWS)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_wr_en   (in_xfer),
        .i_wr_addr (r_row_idx),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_issue),
        .i_rd_addr (r_rd_idx[ROW_IDX_W-1:0]),
        .o_rd_data (rd_data)
    );

    // Move from the read register to the output register when the output is free.
    assign move = r_rd_pend && (!r_out_valid || !i_out_stall);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_FILL: begin
                if (in_xfer && (r_row_idx == LAST_ROW)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (rd_issue && (r_rd_idx == LAST_WORD)) begin
                    n_state = ST_FILL;
                end
            end
            default: n_state = ST_FILL;
        endcase
    end

    // State outputs: input stall and read issue.
    always_comb begin
        o_in_stall = 1'b1;
        rd_issue   = 1'b0;
        unique case (r_state)
            ST_FILL: begin
                o_in_stall = 1'b0;
            end
            ST_DRAIN: begin
                rd_issue = !r_rd_pend || move;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign in_xfer = i_in_valid && !o_in_stall;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_row_idx   <= '0;
            r_rd_idx    <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_row_idx <= r_row_idx + 1'b1;
            end
            if (in_xfer && (r_row_idx == LAST_ROW)) begin
                r_rd_idx <= '0;
            end else if (rd_issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (rd_issue) begin
                r_rd_pend <= 1'b1;
            end else if (move) begin
                r_rd_pend <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Tags travelling with the read, and the output payload.
    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_rd_plane <= r_rd_idx[STORE_IDX_W-1:ROW_IDX_W];
            r_rd_last  <= (r_rd_idx == LAST_WORD);
        end
        if (move) begin
            r_out_word <= rd_data[WORD_W*r_rd_plane +: WORD_W];
            r_out_last <= r_rd_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_plane_word = r_out_word;
    assign o_last_word  = r_out_last;

    // The row counter has wrapped to zero for the whole drain.
    a_drain_row_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (r_row_idx == '0))
        else $error("row counter not zero during drain");

    // Reads are only issued while draining.
    a_read_in_drain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_issue |-> (r_state == ST_DRAIN))
        else $error("memory read outside drain");

    // The sixteenth row starts a drain from the first stored word.
    a_drain_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (r_row_idx == LAST_ROW)) |=> ((r_state == ST_DRAIN) && (r_rd_idx == '0)))
        else $error("drain did not start after last row");

    // The final read of a tile hands the memory back to row filling.
    a_last_read_ends_drain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_issue && (r_rd_idx == LAST_WORD)) |=> (r_state == ST_FILL))
        else $error("drain did not end after the last read");

endmodule

`default_nettype wire
